>>> design/gcrse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcrse_pkg
// Shared types, image layout constants and the 4-to-5 GCR code table.
// ----------------------------------------------------------------------------
package gcrse_pkg;

    localparam int GAP_BYTES = 9;

    localparam int OFF_W = 9;

    localparam logic [OFF_W-1:0] SYNC_HDR_OFF  = OFF_W'(0);
    localparam logic [OFF_W-1:0] HDR_OFF       = OFF_W'(5);
    localparam logic [OFF_W-1:0] HDR_OFF_2     = OFF_W'(10);
    localparam logic [OFF_W-1:0] DATA_SYNC_OFF = OFF_W'(15 + GAP_BYTES);
    localparam logic [OFF_W-1:0] DATA_OFF      = OFF_W'(20 + GAP_BYTES);
    localparam logic [OFF_W-1:0] LAST_GRP_OFF  = OFF_W'(20 + GAP_BYTES + 5 * 64);
    localparam logic [OFF_W-1:0] LAST_OFF      = OFF_W'(24 + GAP_BYTES + 5 * 64);

    localparam logic [2:0] ERR_ID_MISMATCH = 3'd1;
    localparam logic [2:0] ERR_HDR_CHKSUM  = 3'd2;
    localparam logic [2:0] ERR_HDR_MARK    = 3'd3;
    localparam logic [2:0] ERR_DATA_CHKSUM = 3'd4;
    localparam logic [2:0] ERR_DATA_MARK   = 3'd5;

    localparam logic [7:0] HDR_MARK   = 8'h08;
    localparam logic [7:0] DATA_MARK  = 8'h07;
    localparam logic [7:0] BAD_MARK   = 8'hff;
    localparam logic [7:0] SYNC_BYTE  = 8'hff;
    localparam logic [15:0] HDR_PAD   = 16'h0f0f;
    localparam logic [39:0] SYNC_BITS = {5{SYNC_BYTE}};

    // depth must be a power of two
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [4:0] GCR_CODE [16] = '{
        5'h0a, 5'h0b, 5'h12, 5'h13, 5'h0e, 5'h0f, 5'h16, 5'h17,
        5'h09, 5'h19, 5'h1a, 5'h1b, 5'h0d, 5'h1d, 5'h1e, 5'h15
    };

    typedef enum logic [1:0] {
        FR_DATA,
        FR_HDR0,
        FR_HDR1,
        FR_SYNC2
    } front_state_t;

    // One entry of the command queue: a 4-byte group or a sync run.
    typedef struct packed {
        logic             sync;
        logic [31:0]      word;
        logic [OFF_W-1:0] offset;
        logic             fin;
    } cmd_t;

    function automatic logic [39:0] gcr_encode(input logic [31:0] word);
        logic [39:0] bits;
        bits = '0;
        for (int j = 0; j < 8; j++)
        begin
            bits[39-5*j -: 5] = GCR_CODE[word[31-4*j -: 4]];
        end
        return bits;
    endfunction

endpackage
`default_nettype wire

>>> design/gcr_sector_image_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcr_sector_image_encoder
// Turns the 256 payload bytes of a sector into its GCR coded image bytes.
//
//   channel   handshake      payload
//   input     push / full    data_byte, error_kind, track_number,
//                            sector_number, id_one, id_two
//   result    empty / pop    gcr_byte, image_offset, last
//
// An item is taken every cycle while the command queue has room and no header
// is going out; after byte zero of a sector full stays high while the header
// goes out. The back end gives one image byte a cycle while the result side
// pops, and each sector of 256 items yields 345 image bytes.
// Reset clears counters, checksum and queues. A held pop stalls the back end,
// and the full four-entry queue then stalls the input.
// ----------------------------------------------------------------------------
module gcr_sector_image_encoder
    import gcrse_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [7:0]       data_byte,
    input  wire logic [2:0]       error_kind,
    input  wire logic [7:0]       track_number,
    input  wire logic [7:0]       sector_number,
    input  wire logic [7:0]       id_one,
    input  wire logic [7:0]       id_two,
    output logic                  empty,
    input  wire logic             pop,
    output logic [7:0]            gcr_byte,
    output logic [OFF_W-1:0]      image_offset,
    output logic                  last
);

    cmd_t q_wcmd, q_rcmd;
    logic q_push, q_full, q_pop, q_valid;

    gcrse_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .error_kind    (error_kind),
        .track_number  (track_number),
        .sector_number (sector_number),
        .id_one        (id_one),
        .id_two        (id_two),
        .q_push        (q_push),
        .q_cmd         (q_wcmd),
        .q_full        (q_full)
    );

    gcrse_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_wcmd  (q_wcmd),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_rcmd  (q_rcmd),
        .q_valid (q_valid)
    );

    gcrse_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_rcmd       (q_rcmd),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .gcr_byte     (gcr_byte),
        .image_offset (image_offset),
        .last         (last)
    );

endmodule
`default_nettype wire

>>> design/gcrse_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcrse_front
// Accepts payload items, keeps checksum and group state, and issues group
// and sync commands; after byte zero it issues the header words and data sync.
// ----------------------------------------------------------------------------
module gcrse_front
    import gcrse_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] data_byte,
    input  wire logic [2:0] error_kind,
    input  wire logic [7:0] track_number,
    input  wire logic [7:0] sector_number,
    input  wire logic [7:0] id_one,
    input  wire logic [7:0] id_two,
    output logic            q_push,
    output cmd_t            q_cmd,
    input  wire logic       q_full
);

    front_state_t state_reg, state_next;

    logic [7:0]  byte_count_reg, byte_count_next;
    logic [7:0]  cks_reg, cks_next;
    logic [23:0] pending_reg, pending_next;
    logic [31:0] hw0_reg, hw1_reg;
    logic [31:0] hw0_next, hw1_next;

    logic        accept;
    logic        first_byte;
    logic        last_byte;
    logic        group_byte;
    logic [7:0]  id_one_x;
    logic [7:0]  hdr_chk;
    logic [7:0]  cks_base;
    logic [23:0] pending_base;
    logic [5:0]  grp_idx;
    logic [OFF_W-1:0] grp_off;

    assign accept     = push && !full;
    assign first_byte = (byte_count_reg == 8'd0);
    assign last_byte  = (byte_count_reg == 8'hff);
    assign group_byte = (byte_count_reg[1:0] == 2'd2);
    assign grp_idx    = byte_count_reg[7:2];
    assign grp_off    = DATA_OFF + OFF_W'({grp_idx, 2'b00}) + OFF_W'(grp_idx);

    // header words
    always_comb
    begin
        id_one_x = id_one ^ {8{error_kind == ERR_ID_MISMATCH}};
        hdr_chk  = {8{error_kind == ERR_HDR_CHKSUM}} ^ sector_number ^ track_number
                 ^ id_two ^ id_one_x;
        hw0_next = {(error_kind == ERR_HDR_MARK) ? BAD_MARK : HDR_MARK,
                    hdr_chk, sector_number, track_number};
        hw1_next = {id_two, id_one_x, HDR_PAD};
    end

    // data path state
    always_comb
    begin
        cks_base     = first_byte ? {8{error_kind == ERR_DATA_CHKSUM}} : cks_reg;
        pending_base = first_byte
                     ? {16'h0, (error_kind == ERR_DATA_MARK) ? BAD_MARK : DATA_MARK}
                     : pending_reg;
        cks_next     = cks_base ^ data_byte;
        byte_count_next = byte_count_reg + 8'd1;
        if (last_byte || group_byte)
        begin
            pending_next = '0;
        end
        else
        begin
            pending_next = {pending_base[15:0], data_byte};
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FR_DATA:
            begin
                if (accept && first_byte)
                begin
                    state_next = FR_HDR0;
                end
            end
            FR_HDR0:
            begin
                if (!q_full)
                begin
                    state_next = FR_HDR1;
                end
            end
            FR_HDR1:
            begin
                if (!q_full)
                begin
                    state_next = FR_SYNC2;
                end
            end
            FR_SYNC2:
            begin
                if (!q_full)
                begin
                    state_next = FR_DATA;
                end
            end
            default:
            begin
                state_next = FR_DATA;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        full   = 1'b1;
        q_push = 1'b0;
        q_cmd  = '{sync: 1'b0, word: '0, offset: '0, fin: 1'b0};
        unique case (state_reg)
            FR_DATA:
            begin
                full = q_full;
                priority if (first_byte)
                begin
                    q_push = accept;
                    q_cmd  = '{sync: 1'b1, word: '0, offset: SYNC_HDR_OFF, fin: 1'b0};
                end
                else if (last_byte)
                begin
                    q_push = accept;
                    q_cmd  = '{sync: 1'b0, word: {data_byte, cks_next, 16'h0},
                               offset: LAST_GRP_OFF, fin: 1'b1};
                end
                else if (group_byte)
                begin
                    q_push = accept;
                    q_cmd  = '{sync: 1'b0, word: {pending_reg, data_byte},
                               offset: grp_off, fin: 1'b0};
                end
                else
                begin
                    q_push = 1'b0;
                end
            end
            FR_HDR0:
            begin
                q_push = !q_full;
                q_cmd  = '{sync: 1'b0, word: hw0_reg, offset: HDR_OFF, fin: 1'b0};
            end
            FR_HDR1:
            begin
                q_push = !q_full;
                q_cmd  = '{sync: 1'b0, word: hw1_reg, offset: HDR_OFF_2, fin: 1'b0};
            end
            FR_SYNC2:
            begin
                q_push = !q_full;
                q_cmd  = '{sync: 1'b1, word: '0, offset: DATA_SYNC_OFF, fin: 1'b0};
            end
            default:
            begin
                full = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FR_DATA;
            byte_count_reg <= '0;
            cks_reg        <= '0;
            pending_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                byte_count_reg <= byte_count_next;
                cks_reg        <= cks_next;
                pending_reg    <= pending_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && first_byte)
        begin
            hw0_reg <= hw0_next;
            hw1_reg <= hw1_next;
        end
    end

endmodule
`default_nettype wire

>>> design/gcrse_cmd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcrse_cmd_queue
// Short command FIFO between the front and the back.
// ----------------------------------------------------------------------------
module gcrse_cmd_queue
    import gcrse_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_push,
    input  cmd_t      q_wcmd,
    output logic      q_full,
    input  wire logic q_pop,
    output cmd_t      q_rcmd,
    output logic      q_valid
);

    cmd_t mem_reg [QDEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign q_full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_rcmd  = mem_reg[rd_ptr_reg];
    assign do_push = q_push && !q_full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(do_push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(do_pop);
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= q_wcmd;
        end
    end

endmodule
`default_nettype wire

>>> design/gcrse_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcrse_back
// Expands each command into five image bytes through an output register,
// one a cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module gcrse_back
    import gcrse_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  cmd_t                  q_rcmd,
    input  wire logic             q_valid,
    output logic                  q_pop,
    output logic                  empty,
    input  wire logic             pop,
    output logic [7:0]            gcr_byte,
    output logic [OFF_W-1:0]      image_offset,
    output logic                  last
);

    logic             busy_reg, busy_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [39:0]      bits_reg, bits_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic             fin_reg;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg;
    logic [OFF_W-1:0] out_off_reg;
    logic             out_last_reg;

    logic adv, emit, done, load;

    assign adv   = !out_valid_reg || pop;
    assign emit  = busy_reg && adv;
    assign done  = emit && (cnt_reg == 3'd4);
    assign load  = q_valid && (!busy_reg || done);
    assign q_pop = load;

    assign empty        = !out_valid_reg;
    assign gcr_byte     = out_byte_reg;
    assign image_offset = out_off_reg;
    assign last         = out_last_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        bits_next = bits_reg;
        off_next  = off_reg;
        priority if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            bits_next = q_rcmd.sync ? SYNC_BITS : gcr_encode(q_rcmd.word);
            off_next  = q_rcmd.offset;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (emit)
        begin
            cnt_next  = cnt_reg + 3'd1;
            bits_next = {bits_reg[31:0], 8'h00};
            off_next  = off_reg + OFF_W'(1);
        end
        out_valid_next = emit ? 1'b1 : (pop ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        off_reg  <= off_next;
        if (load)
        begin
            fin_reg <= q_rcmd.fin;
        end
        if (emit)
        begin
            out_byte_reg <= bits_reg[39:32];
            out_off_reg  <= off_reg;
            out_last_reg <= fin_reg && (cnt_reg == 3'd4);
        end
    end

endmodule
`default_nettype wire

>>> design/gcrse_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcrse_checker
// Port-level checks on the result stream of the sector image encoder.
// ----------------------------------------------------------------------------
module gcrse_checker
    import gcrse_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             empty,
    input  wire logic             pop,
    input  wire logic [7:0]       gcr_byte,
    input  wire logic [OFF_W-1:0] image_offset,
    input  wire logic             last
);

    // waiting item holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(gcr_byte) && $stable(image_offset)
                              && $stable(last)))
        else $error("result item changed while stalled");

    // last only on the final image byte
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last) |-> (image_offset == LAST_OFF))
        else $error("last on wrong offset");

    // sync bytes at the head of the image
    a_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (image_offset < HDR_OFF)) |-> (gcr_byte == SYNC_BYTE))
        else $error("bad sync byte");

    // offsets run in order, skipping the gap
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last) |=>
            (empty || (image_offset == $past(image_offset) + OFF_W'(1))
             || (($past(image_offset) == HDR_OFF_2 + OFF_W'(4))
                 && (image_offset == DATA_SYNC_OFF))))
        else $error("image offset out of order");

    // a new sector starts at offset zero
    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && last) |=> (empty || (image_offset == SYNC_HDR_OFF)))
        else $error("sector does not restart at zero");

endmodule

bind gcr_sector_image_encoder gcrse_checker u_gcrse_checker (.*);
`default_nettype wire

>>> tb/tb_gcr_sector_image_encoder.sv
// ----------------------------------------------------------------------------
// tb_gcr_sector_image_encoder
// Self-checking bench for the GCR sector image encoder. Whole sectors of
// payload bytes are pushed, each with its header fields and an error kind.
// A behavioural encoder builds the expected image bytes with their offsets
// and the final-byte flag. Every popped byte is compared with them in order.
// Sector zero opens with a short directed table. The next sector uses
// random content with a shuffled error kind. Both sides idle in
// random bursts, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_gcr_sector_image_encoder
    import gcrse_pkg::*;
();

    localparam int N_SECTORS   = 2;
    localparam int N_ITEMS     = N_SECTORS * 256;
    localparam int DIR_ROWS    = 16;
    localparam int IMAGE_BYTES = 345;
    localparam int QUIET_FROM  = (N_SECTORS - 1) * IMAGE_BYTES;
    localparam int HOLD_AT     = 200;
    localparam int HOLD_CYCLES = 60;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    localparam logic [7:0]  MARK_HEADER = 8'h08;
    localparam logic [7:0]  MARK_DATA   = 8'h07;
    localparam logic [7:0]  MARK_BROKEN = 8'hff;
    localparam logic [7:0]  SYNC_VAL    = 8'hff;
    localparam logic [15:0] PAD_WORD    = 16'h0f0f;

    localparam int OFS_SYNC_A = 0;
    localparam int OFS_HDR_A  = 5;
    localparam int OFS_HDR_B  = 10;
    localparam int OFS_SYNC_B = 15 + GAP_BYTES;
    localparam int OFS_DATA   = 20 + GAP_BYTES;
    localparam int OFS_TAIL   = 20 + GAP_BYTES + 5 * 64;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] kind;
        logic [7:0] track;
        logic [7:0] sect;
        logic [7:0] id1;
        logic [7:0] id2;
        logic       typed;
        logic [4:0] t_k;
        logic [7:0] t_byte;
        logic [8:0] t_off;
    } stim_row_t;

    typedef struct packed {
        logic [7:0]       gcr;
        logic [OFF_W-1:0] offset;
        logic             fin;
    } image_byte_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    logic [7:0]       data_byte = 8'h00;
    logic [2:0]       error_kind = 3'd0;
    logic [7:0]       track_number = 8'h00;
    logic [7:0]       sector_number = 8'h00;
    logic [7:0]       id_one = 8'h00;
    logic [7:0]       id_two = 8'h00;
    logic             empty;
    logic             pop = 1'b0;
    logic [7:0]       gcr_byte;
    logic [OFF_W-1:0] image_offset;
    logic             last;

    image_byte_t image_due[$];

    // behavioural encoder state
    logic [7:0]  sec_pos = 8'h00;
    logic [7:0]  sec_xor = 8'h00;
    logic [23:0] grp_bytes = 24'h0;
    logic [2:0]  sec_kind = 3'd0;
    int          res_k;
    int          override_k;
    image_byte_t override_val;

    logic [2:0]  kind_order[8];

    stim_row_t   offered;
    logic        have_item = 1'b0;
    int          items_made = 0;
    int          items_sent = 0;
    int          send_gap = 0;
    logic        stim_done = 1'b0;

    int          bytes_taken = 0;
    int          hold_left = 0;
    int          stall_left = 0;
    logic        hold_done = 1'b0;
    int          mismatches = 0;
    int          idle_cycles = 0;

    gcr_sector_image_encoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .error_kind    (error_kind),
        .track_number  (track_number),
        .sector_number (sector_number),
        .id_one        (id_one),
        .id_two        (id_two),
        .empty         (empty),
        .pop           (pop),
        .gcr_byte      (gcr_byte),
        .image_offset  (image_offset),
        .last          (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [4:0] gcr5(input logic [3:0] nib);
        logic [4:0] c;
        case (nib)
            4'h0: c = 5'h0a;
            4'h1: c = 5'h0b;
            4'h2: c = 5'h12;
            4'h3: c = 5'h13;
            4'h4: c = 5'h0e;
            4'h5: c = 5'h0f;
            4'h6: c = 5'h16;
            4'h7: c = 5'h17;
            4'h8: c = 5'h09;
            4'h9: c = 5'h19;
            4'ha: c = 5'h1a;
            4'hb: c = 5'h1b;
            4'hc: c = 5'h0d;
            4'hd: c = 5'h1d;
            4'he: c = 5'h1e;
            default: c = 5'h15;
        endcase
        return c;
    endfunction

    task automatic put_image_byte(input logic [7:0] b, input int off, input logic fin);
        image_byte_t e;
        e.gcr    = b;
        e.offset = OFF_W'(off);
        e.fin    = fin;
        if (res_k == override_k)
            image_due.push_back(override_val);
        else
            image_due.push_back(e);
        res_k = res_k + 1;
    endtask

    task automatic put_sync_run(input int off);
        for (int j = 0; j < 5; j++)
        begin
            put_image_byte(SYNC_VAL, off + j, 1'b0);
        end
    endtask

    task automatic put_gcr_group(input logic [31:0] w, input int off, input logic fin);
        logic [39:0] bits;
        bits = '0;
        for (int j = 0; j < 8; j++)
        begin
            bits = {bits[34:0], gcr5(w[31-4*j -: 4])};
        end
        for (int j = 0; j < 5; j++)
        begin
            put_image_byte(bits[39-8*j -: 8], off + j, fin && (j == 4));
        end
    endtask

    task automatic encode_sector_byte(input stim_row_t s);
        logic [7:0] id1_out;
        logic [7:0] hdr_chk;
        logic [7:0] hdr_mark;
        logic [7:0] pos;
        pos = sec_pos;
        res_k = 0;
        override_k = s.typed ? int'(s.t_k) : -1;
        override_val = '{gcr: s.t_byte, offset: s.t_off, fin: 1'b0};
        if (pos == 8'd0)
        begin
            sec_kind = s.kind;
            id1_out  = (s.kind == ERR_ID_MISMATCH) ? ~s.id1 : s.id1;
            hdr_chk  = s.sect ^ s.track ^ s.id2 ^ id1_out;
            if (s.kind == ERR_HDR_CHKSUM)
                hdr_chk = ~hdr_chk;
            hdr_mark = (s.kind == ERR_HDR_MARK) ? MARK_BROKEN : MARK_HEADER;
            put_sync_run(OFS_SYNC_A);
            put_gcr_group({hdr_mark, hdr_chk, s.sect, s.track}, OFS_HDR_A, 1'b0);
            put_gcr_group({s.id2, id1_out, PAD_WORD}, OFS_HDR_B, 1'b0);
            put_sync_run(OFS_SYNC_B);
            sec_xor   = (sec_kind == ERR_DATA_CHKSUM) ? 8'hff : 8'h00;
            grp_bytes = {16'h0, (sec_kind == ERR_DATA_MARK) ? MARK_BROKEN : MARK_DATA};
        end
        sec_xor = sec_xor ^ s.data;
        if (pos == 8'd255)
        begin
            put_gcr_group({s.data, sec_xor, 16'h0}, OFS_TAIL, 1'b1);
            grp_bytes = '0;
        end
        else if (pos[1:0] == 2'd2)
        begin
            put_gcr_group({grp_bytes, s.data}, OFS_DATA + 5 * ((int'(pos) - 2) >> 2), 1'b0);
            grp_bytes = '0;
        end
        else
        begin
            grp_bytes = {grp_bytes[15:0], s.data};
        end
        sec_pos = pos + 8'd1;
    endtask

    // sector zero opening: header extremes, then later header fields that must be ignored
    function automatic stim_row_t directed_row(input int r);
        stim_row_t t;
        case (r)
            0:  t = '{8'h00, ERR_HDR_MARK, 8'hff, 8'hff, 8'h00, 8'hff, 1'b1, 5'd5, 8'had, 9'd5};
            1:  t = '{8'hff, ERR_ID_MISMATCH, 8'h00, 8'h00, 8'hff, 8'h00, 1'b0, 5'd0, 8'h00, 9'd0};
            2:  t = '{8'h80, ERR_DATA_MARK, 8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 5'd0, 8'h00, 9'd0};
            3:  t = '{8'h01, ERR_DATA_CHKSUM, 8'h00, 8'hff, 8'h00, 8'hff, 1'b0, 5'd0, 8'h00, 9'd0};
            4:  t = '{8'h55, ERR_HDR_CHKSUM, 8'h55, 8'haa, 8'h55, 8'haa, 1'b0, 5'd0, 8'h00, 9'd0};
            5:  t = '{8'haa, KIND_SPARE_7, 8'haa, 8'h55, 8'haa, 8'h55, 1'b0, 5'd0, 8'h00, 9'd0};
            6:  t = '{8'h00, ERR_NONE, 8'h01, 8'h80, 8'h01, 8'h80, 1'b0, 5'd0, 8'h00, 9'd0};
            7:  t = '{8'hff, KIND_SPARE_6, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0, 8'h00, 9'd0};
            8:  t = '{8'h0f, ERR_HDR_MARK, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 5'd0, 8'h00, 9'd0};
            9:  t = '{8'hf0, ERR_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0, 8'h00, 9'd0};
            10: t = '{8'h12, ERR_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0, 8'h00, 9'd0};
            11: t = '{8'h34, ERR_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0, 8'h00, 9'd0};
            12: t = '{8'hff, ERR_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0, 8'h00, 9'd0};
            13: t = '{8'hff, ERR_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0, 8'h00, 9'd0};
            14: t = '{8'hff, ERR_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0, 8'h00, 9'd0};
            default: t = '{8'hff, ERR_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0, 8'h00, 9'd0};
        endcase
        return t;
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [7:0] v;
        case ($urandom_range(0, 7))
            0: v = 8'h00;
            1: v = 8'hff;
            default: v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    function automatic stim_row_t make_item(input int idx);
        stim_row_t t;
        int pos;
        int sec;
        pos = idx % 256;
        sec = idx / 256;
        if (idx < DIR_ROWS)
            t = directed_row(idx);
        else
        begin
            t = '0;
            t.data  = rand_byte();
            t.kind  = (pos == 0) ? kind_order[(sec - 1) % 8] : 3'($urandom_range(0, 7));
            t.track = rand_byte();
            t.sect  = rand_byte();
            t.id1   = rand_byte();
            t.id2   = rand_byte();
        end
        return t;
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push          <= 1'b0;
            data_byte     <= 8'h00;
            error_kind    <= 3'd0;
            track_number  <= 8'h00;
            sector_number <= 8'h00;
            id_one        <= 8'h00;
            id_two        <= 8'h00;
        end
        else
        begin
            if (push && !full)
            begin
                encode_sector_byte(offered);
                items_sent = items_sent + 1;
                have_item  = 1'b0;
            end
            if (!have_item && items_made < N_ITEMS)
            begin
                offered    = make_item(items_made);
                items_made = items_made + 1;
                have_item  = 1'b1;
            end
            if (send_gap > 0)
                send_gap = send_gap - 1;
            else if (items_made <= N_ITEMS - 256 && $urandom_range(0, 7) == 0)
                send_gap = $urandom_range(1, 5);
            push          <= have_item && (send_gap == 0);
            data_byte     <= offered.data;
            error_kind    <= offered.kind;
            track_number  <= offered.track;
            sector_number <= offered.sect;
            id_one        <= offered.id1;
            id_two        <= offered.id2;
            if (items_sent == N_ITEMS)
                stim_done <= 1'b1;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        image_byte_t exp_b;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (image_due.size() == 0)
                begin
                    $display("%0t: unexpected image byte %02h offset %0d last %0b",
                             $time, gcr_byte, image_offset, last);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    exp_b = image_due.pop_front();
                    if (gcr_byte !== exp_b.gcr)
                    begin
                        $display("%0t: gcr_byte expected %02h actual %02h",
                                 $time, exp_b.gcr, gcr_byte);
                        mismatches = mismatches + 1;
                    end
                    if (image_offset !== exp_b.offset)
                    begin
                        $display("%0t: image_offset expected %0d actual %0d",
                                 $time, exp_b.offset, image_offset);
                        mismatches = mismatches + 1;
                    end
                    if (last !== exp_b.fin)
                    begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, exp_b.fin, last);
                        mismatches = mismatches + 1;
                    end
                end
                bytes_taken = bytes_taken + 1;
            end
            if (hold_left > 0)
                hold_left = hold_left - 1;
            else if (!hold_done && bytes_taken >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            else if (stall_left > 0)
                stall_left = stall_left - 1;
            else if (bytes_taken < QUIET_FROM && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 5);
            pop <= (hold_left == 0) && (stall_left == 0);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT)
            begin
                $display("%0t: no progress, %0d image bytes outstanding",
                         $time, image_due.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic [2:0] tmp;
        int         j;
        for (int i = 0; i < 8; i++)
        begin
            kind_order[i] = 3'(i);
        end
        for (int i = 7; i > 0; i--)
        begin
            j             = $urandom_range(0, i);
            tmp           = kind_order[i];
            kind_order[i] = kind_order[j];
            kind_order[j] = tmp;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        while (!stim_done || image_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
design/gcrse_pkg.sv
design/gcrse_front.sv
design/gcrse_cmd_queue.sv
design/gcrse_back.sv
design/gcr_sector_image_encoder.sv
design/gcrse_checker.sv
tb/tb_gcr_sector_image_encoder.sv
